/* src/rcc_pkg.sv */
`default_nettype none

package rcc_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned CH_W      = 3;
    localparam int unsigned NORM_W    = 10;

    // Calibration register file
    localparam int unsigned CAL_REGS  = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 34;

    // Calibration word layout
    localparam int unsigned CAL_BLACK_LSB = 0;
    localparam int unsigned CAL_WHITE_LSB = 12;
    localparam int unsigned CAL_THR_LSB   = 24;
    localparam int unsigned CAL_THR_W     = 10;

    // Incoming request: one channel, five ambient and five reflected samples
    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] ambient_sample_0;
        logic [SAMPLE_W-1:0] ambient_sample_1;
        logic [SAMPLE_W-1:0] ambient_sample_2;
        logic [SAMPLE_W-1:0] ambient_sample_3;
        logic [SAMPLE_W-1:0] ambient_sample_4;
        logic [SAMPLE_W-1:0] reflect_sample_0;
        logic [SAMPLE_W-1:0] reflect_sample_1;
        logic [SAMPLE_W-1:0] reflect_sample_2;
        logic [SAMPLE_W-1:0] reflect_sample_3;
        logic [SAMPLE_W-1:0] reflect_sample_4;
    } t_in_req;

    // Outgoing result
    typedef struct packed {
        logic [CH_W-1:0]     out_channel;
        logic [SAMPLE_W-1:0] effective_level;
        logic [SAMPLE_W-1:0] averaged_level;
        logic [NORM_W-1:0]   normalized_level;
        logic                line_detected;
    } t_out_req;

endpackage

`default_nettype wire

/* src/rcc_div.sv */
`default_nettype none

// Radix-4 restoring divider, two quotient bits per cycle
module rcc_div #(
    parameter int unsigned DVW = 22,
    parameter int unsigned DSW = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [DVW-1:0] i_dividend,
    input  wire logic [DSW-1:0] i_divisor,
    output logic                o_done,
    output logic [DVW-1:0]      o_quotient
);

    localparam int unsigned ITER = (DVW + 1) / 2;
    localparam int unsigned QW   = 2 * ITER;
    localparam int unsigned CNW  = $clog2(ITER + 1);

    logic [QW-1:0]  r_q;
    logic [DSW-1:0] r_rem;
    logic [DSW-1:0] r_dvs;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [DSW:0]   w_t1, w_t2;
    logic           w_ge1, w_ge2;
    logic [DSW-1:0] w_r1, w_r2;

    // Two dependent compare-subtract steps
    always_comb begin
        w_t1  = {r_rem, r_q[QW-1]};
        w_ge1 = (w_t1 >= {1'b0, r_dvs});
        w_r1  = w_ge1 ? DSW'(w_t1 - {1'b0, r_dvs}) : DSW'(w_t1);
        w_t2  = {w_r1, r_q[QW-2]};
        w_ge2 = (w_t2 >= {1'b0, r_dvs});
        w_r2  = w_ge2 ? DSW'(w_t2 - {1'b0, r_dvs}) : DSW'(w_t2);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= QW'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[QW-3:0], w_ge1, w_ge2};
            r_rem <= w_r2;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q[DVW-1:0];

endmodule

`default_nettype wire

/* src/reflectance_channel_conditioner_core.sv */
// Steps: median filters, effective level, history write, history read, average,
//   normalization, line decision, result. The divider is skipped when white <= black
//   or the average is not strictly inside black..white; an unknown channel goes to
//   the result directly. Requests are taken one at a time; the divider (two bits a
//   cycle) runs at most once per request; history memory is read one entry a cycle.
// Reset: synchronous, active low; clears calibration, history valid bits, pointers and
//   line states. History entries not yet written read as zero.
`default_nettype none

module reflectance_channel_conditioner_core #(
    parameter int unsigned CHANNELS      = 7,
    parameter int unsigned MEDIAN_TAPS   = 5,
    parameter int unsigned AVERAGE_DEPTH = 4,
    parameter int unsigned NORM_MAX      = 999
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_req_valid,
    output logic                                   o_req_ready,
    input  wire rcc_pkg::t_in_req                  i_req,
    output logic                                   o_rsp_valid,
    input  wire logic                              i_rsp_ready,
    output rcc_pkg::t_out_req                      o_rsp,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [rcc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rcc_pkg::CFG_W-1:0]         i_cfg_wdata
);

    localparam int unsigned SW        = rcc_pkg::SAMPLE_W;
    localparam int unsigned MT        = (MEDIAN_TAPS > 5) ? 5 : MEDIAN_TAPS;
    localparam int unsigned MID       = MT / 2;
    localparam int unsigned MEM_DEPTH = CHANNELS * AVERAGE_DEPTH;
    localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned PTRW      = $clog2(AVERAGE_DEPTH);
    localparam int unsigned SUMW      = SW + $clog2(AVERAGE_DEPTH);
    localparam int unsigned NW        = $clog2(NORM_MAX + 1);
    localparam int unsigned CW        = (NW > rcc_pkg::NORM_W) ? NW : rcc_pkg::NORM_W;
    localparam int unsigned PW        = SW + NW;
    localparam int unsigned DVW       = PW;
    // Average by reciprocal multiply: exact floor for every sum below 2**SUMW
    localparam int unsigned RSH       = SUMW + $clog2(AVERAGE_DEPTH);
    localparam int unsigned RCP       = ((2 ** RSH) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
    localparam int unsigned APW       = SUMW + RSH;

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_EFF       = 11'b000_0000_0010,
        ST_WRITE     = 11'b000_0000_0100,
        ST_READ      = 11'b000_0000_1000,
        ST_LAST      = 11'b000_0001_0000,
        ST_AVG       = 11'b000_0010_0000,
        ST_NORM      = 11'b000_0100_0000,
        ST_NORM_GO   = 11'b000_1000_0000,
        ST_NORM_WAIT = 11'b001_0000_0000,
        ST_LINE      = 11'b010_0000_0000,
        ST_DONE      = 11'b100_0000_0000
    } t_state;

    // Median by rank: ties broken by sample position
    function automatic logic [SW-1:0] f_median(input logic [4:0][SW-1:0] v);
        logic [2:0]    rank;
        logic [SW-1:0] med;
        med = v[0];
        for (int i = 0; i < MT; i++) begin
            rank = '0;
            for (int j = 0; j < MT; j++) begin
                if ((j != i) && ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i)))) begin
                    rank = rank + 1'b1;
                end
            end
            if (rank == 3'(MID)) begin
                med = v[i];
            end
        end
        return med;
    endfunction

    t_state                   r_state, n_state;
    logic [rcc_pkg::CFG_W-1:0] r_cal [rcc_pkg::CAL_REGS];
    logic [PTRW-1:0]          r_ptr [CHANNELS];
    logic                     r_lstate [CHANNELS];
    logic                     r_hv [MEM_DEPTH];
    logic [SW-1:0]            r_mem [MEM_DEPTH];

    logic [rcc_pkg::CH_W-1:0] r_ch;
    logic                     r_ch_ok;
    logic [SW-1:0]            r_amb, r_ref, r_eff, r_avg, r_span;
    logic [AW-1:0]            r_base;
    logic [PTRW-1:0]          r_idx;
    logic                     r_rd_live, r_rd_ok;
    logic [SW-1:0]            r_rd_data;
    logic [SUMW-1:0]          r_sum;
    logic [PW-1:0]            r_prod;
    logic [CW-1:0]            r_norm;
    logic                     r_line;
    rcc_pkg::t_out_req        r_out;
    logic                     r_out_valid;

    logic                     w_accept, w_out_free;
    logic [CHW-1:0]           w_ci;
    logic [rcc_pkg::CFG_W-1:0] w_cal;
    logic [SW-1:0]            w_black, w_white;
    logic [rcc_pkg::CAL_THR_W-1:0] w_thr_raw;
    logic [CW-1:0]            w_thr;
    logic [AW-1:0]            w_wr_addr, w_rd_addr;
    logic                     w_div_start, w_div_done;
    logic [DVW-1:0]           w_dvd, w_quot;
    logic [SW-1:0]            w_dvs;
    logic [APW-1:0]           w_avg_prod;

    assign w_accept    = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign w_ci        = r_ch[CHW-1:0];

    // Calibration fields of the current channel
    assign w_cal     = r_cal[r_ch];
    assign w_black   = w_cal[rcc_pkg::CAL_BLACK_LSB +: SW];
    assign w_white   = w_cal[rcc_pkg::CAL_WHITE_LSB +: SW];
    assign w_thr_raw = w_cal[rcc_pkg::CAL_THR_LSB +: rcc_pkg::CAL_THR_W];
    assign w_thr     = (CW'(w_thr_raw) > CW'(NORM_MAX)) ? CW'(NORM_MAX) : CW'(w_thr_raw);

    assign w_wr_addr = r_base + AW'(r_ptr[w_ci]);
    assign w_rd_addr = r_base + AW'(r_idx);

    // History sum times the reciprocal of the depth
    assign w_avg_prod = APW'(r_sum) * APW'(RCP);

    // Divider for the span mapping
    assign w_div_start = (r_state == ST_NORM_GO);
    assign w_dvd = DVW'(r_prod);
    assign w_dvs = r_span;

    rcc_div #(
        .DVW (DVW),
        .DSW (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (w_accept) n_state = ST_EFF;
            ST_EFF:       n_state = (32'(r_ch) < CHANNELS) ? ST_WRITE : ST_DONE;
            ST_WRITE:     n_state = ST_READ;
            ST_READ:      if (r_idx == PTRW'(AVERAGE_DEPTH - 1)) n_state = ST_LAST;
            ST_LAST:      n_state = ST_AVG;
            ST_AVG:       n_state = ST_NORM;
            ST_NORM: begin
                if ((w_white > w_black) && (r_avg > w_black) && (r_avg < w_white)) begin
                    n_state = ST_NORM_GO;
                end else begin
                    n_state = ST_LINE;
                end
            end
            ST_NORM_GO:   n_state = ST_NORM_WAIT;
            ST_NORM_WAIT: if (w_div_done) n_state = ST_LINE;
            ST_LINE:      n_state = ST_DONE;
            ST_DONE:      if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rd_live   <= 1'b0;
            for (int k = 0; k < rcc_pkg::CAL_REGS; k++) r_cal[k] <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_ptr[k]    <= '0;
                r_lstate[k] <= 1'b0;
            end
            for (int k = 0; k < MEM_DEPTH; k++) r_hv[k] <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_live <= (r_state == ST_READ);

            // calibration writes
            if (i_cfg_wr_en && (32'(i_cfg_idx) < rcc_pkg::CAL_REGS)) begin
                r_cal[i_cfg_idx] <= i_cfg_wdata;
            end

            // history write and pointer advance
            if (r_state == ST_WRITE) begin
                r_hv[w_wr_addr] <= 1'b1;
                r_ptr[w_ci] <= (r_ptr[w_ci] == PTRW'(AVERAGE_DEPTH - 1)) ?
                               '0 : r_ptr[w_ci] + 1'b1;
            end

            // line decision, held on equality
            if (r_state == ST_LINE) begin
                if (r_norm < w_thr) begin
                    r_lstate[w_ci] <= 1'b1;
                end else if (r_norm > w_thr) begin
                    r_lstate[w_ci] <= 1'b0;
                end
            end

            // result register
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // History memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_mem[w_wr_addr] <= r_eff;
        end
        r_rd_data <= r_mem[w_rd_addr];
        r_rd_ok   <= r_hv[w_rd_addr];
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_ch  <= i_req.channel;
                    r_amb <= f_median({i_req.ambient_sample_4, i_req.ambient_sample_3,
                                       i_req.ambient_sample_2, i_req.ambient_sample_1,
                                       i_req.ambient_sample_0});
                    r_ref <= f_median({i_req.reflect_sample_4, i_req.reflect_sample_3,
                                       i_req.reflect_sample_2, i_req.reflect_sample_1,
                                       i_req.reflect_sample_0});
                end
            end
            ST_EFF: begin
                r_eff   <= (r_ref > r_amb) ? r_ref - r_amb : '0;
                r_ch_ok <= (32'(r_ch) < CHANNELS);
                r_base  <= AW'(32'(r_ch) * AVERAGE_DEPTH);
                r_avg   <= '0;
                r_norm  <= '0;
                r_line  <= 1'b0;
            end
            ST_WRITE: begin
                r_idx <= '0;
                r_sum <= '0;
            end
            ST_READ: begin
                r_idx <= r_idx + 1'b1;
            end
            ST_AVG: begin
                r_avg <= w_avg_prod[RSH +: SW];
            end
            ST_NORM: begin
                // clamp cases resolved here; the in-span case goes to the divider
                if (w_white <= w_black) begin
                    r_norm <= CW'(NORM_MAX / 2);
                end else if (r_avg <= w_black) begin
                    r_norm <= '0;
                end else if (r_avg >= w_white) begin
                    r_norm <= CW'(NORM_MAX);
                end
                r_prod <= PW'(r_avg - w_black) * PW'(NORM_MAX);
                r_span <= w_white - w_black;
            end
            ST_NORM_WAIT: begin
                if (w_div_done) r_norm <= w_quot[CW-1:0];
            end
            ST_LINE: begin
                if (r_norm < w_thr) begin
                    r_line <= 1'b1;
                end else if (r_norm > w_thr) begin
                    r_line <= 1'b0;
                end else begin
                    r_line <= r_lstate[w_ci];
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out.out_channel      <= r_ch;
                    r_out.effective_level  <= r_eff;
                    r_out.averaged_level   <= r_avg;
                    r_out.normalized_level <= r_norm[rcc_pkg::NORM_W-1:0];
                    r_out.line_detected    <= r_line & r_ch_ok;
                end
            end
            default: begin
            end
        endcase

        // accumulate history reads as they return
        if (r_rd_live) begin
            r_sum <= r_sum + (r_rd_ok ? SUMW'(r_rd_data) : '0);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire
